// ===== hw/rtl/cdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cepstral delta regression package
// Shared widths, payload types and width helpers of the delta block.
// ----------------------------------------------------------------------------
package cdr_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int CSR_W      = 6;
   localparam int BAND_OUT_W = 5;
   localparam int LAG_OUT_W  = 2;

   localparam int DEFAULT_HALF_WIDTH = 2;
   localparam int DEFAULT_MAX_BANDS  = 32;

   localparam logic [CSR_W-1:0] NUM_BANDS_RESET = CSR_W'(12);

   localparam int POS_LIMIT = 8388607;
   localparam int NEG_LIMIT = 8388608;
   localparam logic [SAMPLE_W-1:0] Q_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] Q_MIN = 24'h800000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] coefficient;
      logic                       final_frame;
   } cdr_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] delta;
      logic [BAND_OUT_W-1:0]      band;
      logic [LAG_OUT_W-1:0]       frame_lag;
      logic                       utterance_end;
   } cdr_rsp_type;

   typedef struct packed {
      logic [BAND_OUT_W-1:0] band;
      logic [LAG_OUT_W-1:0]  frame_lag;
      logic                  utterance_end;
   } cdr_tag_type;

   // 2 * sum k^2 for k = 1..half
   function automatic int denom_of(input int half);
      return half * (half + 1) * (2 * half + 1) / 3;
   endfunction

   // signed width of sum k * (x[f+k] - x[f-k])
   function automatic int num_width_of(input int half);
      return SAMPLE_W + 1 + $clog2(half * (half + 1) / 2 + 1);
   endfunction

endpackage

// ===== hw/rtl/cdr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cepstral delta regression channels
// Valid/ready channels for coefficients, deltas and the band count register.
// ----------------------------------------------------------------------------
interface cdr_req_if;
   import cdr_pkg::*;
   logic        valid;
   logic        ready;
   cdr_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cdr_rsp_if;
   import cdr_pkg::*;
   logic        valid;
   logic        ready;
   cdr_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cdr_csr_if;
   import cdr_pkg::*;
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cdr_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cepstral delta regression divider
// Rounds numerator / (2 * sum k^2) to nearest, ties away from zero, and
// saturates to Q15.8. Three stalling stages, the last is the output register.
// ----------------------------------------------------------------------------
module cdr_divider #(
   parameter int HALF_WIDTH = cdr_pkg::DEFAULT_HALF_WIDTH
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 in_valid,
   output logic                                                 in_ready,
   input  logic signed [cdr_pkg::num_width_of(HALF_WIDTH)-1:0]  in_value,
   input  cdr_pkg::cdr_tag_type                                 in_tag,
   output logic                                                 out_valid,
   input  logic                                                 out_ready,
   output logic signed [cdr_pkg::SAMPLE_W-1:0]                  out_delta,
   output cdr_pkg::cdr_tag_type                                 out_tag
);
   import cdr_pkg::*;

   localparam int NUM_W  = num_width_of(HALF_WIDTH);
   localparam int DENOM  = denom_of(HALF_WIDTH);
   localparam int HALF_D = DENOM / 2;
   localparam logic [NUM_W-1:0] RECIP = NUM_W'((64'd1 << NUM_W) / DENOM);

   logic                  s1_valid_ff;
   logic                  s1_neg_ff;
   logic [NUM_W-1:0]      s1_m_ff;
   cdr_tag_type           s1_tag_ff;
   logic                  s2_valid_ff;
   logic                  s2_neg_ff;
   logic [NUM_W-1:0]      s2_m_ff;
   logic [2*NUM_W-1:0]    s2_prod_ff;
   cdr_tag_type           s2_tag_ff;
   logic                  out_valid_ff;
   logic [SAMPLE_W-1:0]   out_delta_ff;
   cdr_tag_type           out_tag_ff;

   logic                  s1_en;
   logic                  s2_en;
   logic                  s3_en;
   logic [NUM_W-1:0]      mag;
   logic [NUM_W-1:0]      m_in;
   logic [NUM_W-1:0]      q_est;
   logic [NUM_W-1:0]      rem;
   logic [NUM_W-1:0]      q;
   logic [SAMPLE_W-1:0]   delta_in;

   assign s3_en    = !out_valid_ff || out_ready;
   assign s2_en    = !s2_valid_ff || s3_en;
   assign s1_en    = !s1_valid_ff || s2_en;
   assign in_ready = s1_en;

   always_comb begin
      mag  = in_value[NUM_W-1] ? NUM_W'(-in_value) : NUM_W'(in_value);
      m_in = mag + NUM_W'(HALF_D);
   end

   // reciprocal estimate is at most one low
   always_comb begin
      q_est = s2_prod_ff[2*NUM_W-1:NUM_W];
      rem   = s2_m_ff - q_est * NUM_W'(DENOM);
      q     = (rem >= NUM_W'(DENOM)) ? q_est + NUM_W'(1) : q_est;
      if (s2_neg_ff) begin
         delta_in = (q > NUM_W'(NEG_LIMIT)) ? Q_MIN : SAMPLE_W'(NUM_W'(0) - q);
      end else begin
         delta_in = (q > NUM_W'(POS_LIMIT)) ? Q_MAX : SAMPLE_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_neg_ff <= in_value[NUM_W-1];
         s1_m_ff   <= m_in;
         s1_tag_ff <= in_tag;
      end
      if (s2_en) begin
         s2_neg_ff  <= s1_neg_ff;
         s2_m_ff    <= s1_m_ff;
         s2_prod_ff <= (2*NUM_W)'(s1_m_ff) * (2*NUM_W)'(RECIP);
         s2_tag_ff  <= s1_tag_ff;
      end
      if (s3_en) begin
         out_delta_ff <= delta_in;
         out_tag_ff   <= s2_tag_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_delta = out_delta_ff;
   assign out_tag   = out_tag_ff;

endmodule

// ===== hw/rtl/cdr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cepstral delta regression engine
// Frame/band bookkeeping, history memory, window fill and numerator issue.
// ----------------------------------------------------------------------------
module cdr_engine #(
   parameter int HALF_WIDTH = cdr_pkg::DEFAULT_HALF_WIDTH,
   parameter int MAX_BANDS  = cdr_pkg::DEFAULT_MAX_BANDS
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic [cdr_pkg::CSR_W-1:0]                            num_bands,
   input  logic                                                 req_valid,
   output logic                                                 req_ready,
   input  cdr_pkg::cdr_req_type                                 req_payload,
   output logic                                                 num_valid,
   input  logic                                                 num_ready,
   output logic signed [cdr_pkg::num_width_of(HALF_WIDTH)-1:0]  num_value,
   output cdr_pkg::cdr_tag_type                                 num_tag
);
   import cdr_pkg::*;

   localparam int SPAN   = 2 * HALF_WIDTH + 1;
   localparam int DEPTH  = SPAN * MAX_BANDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int SLOT_W = $clog2(SPAN);
   localparam int LW     = $clog2(SPAN + 1);
   localparam int EFF_W  = CSR_W + 1;
   localparam int NUM_W  = num_width_of(HALF_WIDTH);

   typedef enum logic [1:0] {ST_IDLE, ST_FILL, ST_SETTLE, ST_EMIT} state_type;

   state_type                  state_ff;
   state_type                  state_in;

   logic [BAND_W-1:0]          band_cnt_ff;
   logic [LW-1:0]              seen_ff;
   logic [SLOT_W-1:0]          slot_ff;

   logic                       job_valid_ff;
   logic signed [SAMPLE_W-1:0] job_sample_ff;
   logic [BAND_W-1:0]          job_band_ff;
   logic [SLOT_W-1:0]          job_slot_ff;
   logic [LW-1:0]              job_seen_ff;
   logic                       job_final_ff;
   logic                       job_end_ff;

   logic signed [SAMPLE_W-1:0] cur_sample_ff;
   logic [BAND_W-1:0]          cur_band_ff;
   logic [SLOT_W-1:0]          cur_slot_ff;
   logic [LW-1:0]              cur_seen_ff;
   logic                       cur_final_ff;
   logic                       cur_end_ff;

   logic [LW-1:0]              lag_ff;
   logic [LW-1:0]              fill_ff;
   logic                       pend_valid_ff;
   logic                       pend_mem_ff;
   logic signed [SAMPLE_W-1:0] mem_q_ff;
   logic signed [SAMPLE_W-1:0] win_ff [SPAN];
   logic signed [SAMPLE_W-1:0] history_ff [DEPTH];

   logic                       accept;
   logic                       take;
   logic [EFF_W-1:0]           eff;
   logic                       frame_end;
   logic [LW-1:0]              hi_start;
   logic                       need_emit;
   logic [LW-1:0]              lo_lag;
   logic                       emit_go;
   logic                       last_emit;
   logic [LW-1:0]              fill_tot;
   logic [LW-1:0]              fill_raw;
   logic [LW-1:0]              fill_lag;
   logic [SLOT_W:0]            slot_sum;
   logic [SLOT_W-1:0]          rd_slot;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ADDR_W-1:0]          wr_addr;
   logic signed [NUM_W-1:0]    num_acc;

   // front: band / frame bookkeeping at accept
   always_comb begin
      if (num_bands == '0) begin
         eff = EFF_W'(1);
      end else if (EFF_W'(num_bands) > EFF_W'(MAX_BANDS)) begin
         eff = EFF_W'(MAX_BANDS);
      end else begin
         eff = EFF_W'(num_bands);
      end
      frame_end = (EFF_W'(band_cnt_ff) + EFF_W'(1)) >= eff;
   end

   assign take      = (state_ff == ST_IDLE) && job_valid_ff;
   assign req_ready = !job_valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_cnt_ff  <= '0;
         seen_ff      <= '0;
         slot_ff      <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            job_valid_ff <= 1'b1;
            if (frame_end) begin
               band_cnt_ff <= '0;
               if (req_payload.final_frame) begin
                  seen_ff <= '0;
                  slot_ff <= '0;
               end else begin
                  if (seen_ff < LW'(SPAN)) begin
                     seen_ff <= seen_ff + LW'(1);
                  end
                  slot_ff <= (slot_ff == SLOT_W'(SPAN - 1)) ? '0 : slot_ff + SLOT_W'(1);
               end
            end else begin
               band_cnt_ff <= band_cnt_ff + BAND_W'(1);
            end
         end else if (take) begin
            job_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_sample_ff <= req_payload.coefficient;
         job_band_ff   <= band_cnt_ff;
         job_slot_ff   <= slot_ff;
         job_seen_ff   <= seen_ff;
         job_final_ff  <= req_payload.final_frame;
         job_end_ff    <= frame_end;
      end
   end

   // sequencer
   always_comb begin
      if (job_final_ff) begin
         hi_start = (job_seen_ff < LW'(HALF_WIDTH)) ? job_seen_ff : LW'(HALF_WIDTH);
      end else begin
         hi_start = LW'(HALF_WIDTH);
      end
      need_emit = job_final_ff || (job_seen_ff >= LW'(HALF_WIDTH));
      lo_lag    = cur_final_ff ? '0 : LW'(HALF_WIDTH);
      emit_go   = (state_ff == ST_EMIT) && num_ready;
      last_emit = (lag_ff == lo_lag);
   end

   // window fill: taps run from lag hi+N down to hi-N, clamped to [0, seen]
   always_comb begin
      fill_tot = lag_ff + LW'(HALF_WIDTH);
      fill_raw = fill_tot - fill_ff;
      if (fill_ff >= fill_tot) begin
         fill_lag = '0;
      end else if (fill_raw > cur_seen_ff) begin
         fill_lag = cur_seen_ff;
      end else begin
         fill_lag = fill_raw;
      end
      slot_sum = (SLOT_W+1)'(cur_slot_ff) + (SLOT_W+1)'(SPAN) - (SLOT_W+1)'(fill_lag);
      rd_slot  = (slot_sum >= (SLOT_W+1)'(SPAN)) ? SLOT_W'(slot_sum - (SLOT_W+1)'(SPAN))
                                                 : SLOT_W'(slot_sum);
      rd_en    = (state_ff == ST_FILL) && (fill_lag != '0);
      rd_addr  = ADDR_W'(rd_slot) * ADDR_W'(MAX_BANDS) + ADDR_W'(cur_band_ff);
      wr_addr  = ADDR_W'(job_slot_ff) * ADDR_W'(MAX_BANDS) + ADDR_W'(job_band_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && need_emit) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (fill_ff == LW'(SPAN - 1)) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go && last_emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         pend_mem_ff   <= 1'b0;
         fill_ff       <= '0;
         lag_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= (state_ff == ST_FILL);
         pend_mem_ff   <= rd_en;
         if (take) begin
            fill_ff <= '0;
            lag_ff  <= hi_start;
         end else begin
            if (state_ff == ST_FILL) begin
               fill_ff <= fill_ff + LW'(1);
            end
            if (emit_go && !last_emit) begin
               lag_ff <= lag_ff - LW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_sample_ff <= job_sample_ff;
         cur_band_ff   <= job_band_ff;
         cur_slot_ff   <= job_slot_ff;
         cur_seen_ff   <= job_seen_ff;
         cur_final_ff  <= job_final_ff;
         cur_end_ff    <= job_end_ff;
      end
      if (pend_valid_ff || (emit_go && !last_emit)) begin
         for (int j = SPAN - 1; j > 0; j--) begin
            win_ff[j] <= win_ff[j-1];
         end
         win_ff[0] <= (pend_valid_ff && pend_mem_ff) ? mem_q_ff : cur_sample_ff;
      end
   end

   // history memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (take) begin
         history_ff[wr_addr] <= job_sample_ff;
      end
      if (rd_en) begin
         mem_q_ff <= history_ff[rd_addr];
      end
   end

   always_comb begin
      num_acc = '0;
      for (int k = 1; k <= HALF_WIDTH; k++) begin
         num_acc = num_acc + NUM_W'(k) *
                   (NUM_W'(win_ff[HALF_WIDTH-k]) - NUM_W'(win_ff[HALF_WIDTH+k]));
      end
   end

   assign num_valid             = (state_ff == ST_EMIT);
   assign num_value             = num_acc;
   assign num_tag.band          = BAND_OUT_W'(cur_band_ff);
   assign num_tag.frame_lag     = LAG_OUT_W'(lag_ff);
   assign num_tag.utterance_end = cur_final_ff && cur_end_ff && (lag_ff == '0);

endmodule

// ===== hw/rtl/cepstral_delta_regression.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cepstral delta regression
// Regression deltas of cepstral coefficients over +/-HALF_WIDTH frames.
// ----------------------------------------------------------------------------
// req_chan takes one signed Q15.8 coefficient per beat, bands in order, with
// final_frame set on every beat of the utterance's last frame. rsp_chan gives
// one delta beat per result with its band, frame_lag and utterance_end.
// csr_chan writes num_bands; it is always ready. The user must write it only while
// idle; the block itself does not enforce this. A beat that yields a delta takes
// the engine through its fill, settle and emit states, with a further emit for each
// further delta a final-frame beat flushes; beats that yield nothing leave the
// engine idle. In the fill state the engine reads one window tap per cycle from
// the history memory's read port, or takes the current coefficient at lag 0.
// One further coefficient is buffered while the engine works.
// Reset clears band, frame and slot counters and sets num_bands to 12; the
// history memory is not cleared, a slot is always written before it is read.
// When rsp_chan stalls, the divider pipeline holds up to three deltas, then
// the engine waits and req_chan backs up.
// ----------------------------------------------------------------------------
module cepstral_delta_regression #(
   parameter int HALF_WIDTH = cdr_pkg::DEFAULT_HALF_WIDTH,
   parameter int MAX_BANDS  = cdr_pkg::DEFAULT_MAX_BANDS
) (
   input  logic       clock,
   input  logic       reset,
   cdr_req_if.sink    req_chan,
   cdr_rsp_if.source  rsp_chan,
   cdr_csr_if.sink    csr_chan
);
   import cdr_pkg::*;

   localparam int NUM_W = num_width_of(HALF_WIDTH);

   logic [CSR_W-1:0]           num_bands_ff;
   logic                       num_valid;
   logic                       num_ready;
   logic signed [NUM_W-1:0]    num_value;
   cdr_tag_type                num_tag;
   logic                       div_valid;
   logic signed [SAMPLE_W-1:0] div_delta;
   cdr_tag_type                div_tag;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bands_ff <= NUM_BANDS_RESET;
      end else if (csr_chan.valid) begin
         num_bands_ff <= csr_chan.data;
      end
   end

   cdr_engine #(
      .HALF_WIDTH (HALF_WIDTH),
      .MAX_BANDS  (MAX_BANDS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .num_bands   (num_bands_ff),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .num_valid   (num_valid),
      .num_ready   (num_ready),
      .num_value   (num_value),
      .num_tag     (num_tag)
   );

   cdr_divider #(
      .HALF_WIDTH (HALF_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_value  (num_value),
      .in_tag    (num_tag),
      .out_valid (div_valid),
      .out_ready (rsp_chan.ready),
      .out_delta (div_delta),
      .out_tag   (div_tag)
   );

   assign rsp_chan.valid                 = div_valid;
   assign rsp_chan.payload.delta         = div_delta;
   assign rsp_chan.payload.band          = div_tag.band;
   assign rsp_chan.payload.frame_lag     = div_tag.frame_lag;
   assign rsp_chan.payload.utterance_end = div_tag.utterance_end;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cepstral delta regression testbench
// Streams utterances of random coefficients through the delta block with
// random gaps on both channels, predicts each delta beat from a shadow copy
// of the frame history and counters, and checks every beat in order.
// ----------------------------------------------------------------------------
module tb_top;
   import cdr_pkg::*;

   localparam int HW      = DEFAULT_HALF_WIDTH;
   localparam int SPAN    = 2 * HW + 1;
   localparam int MAX_B   = DEFAULT_MAX_BANDS;
   localparam int ITEMS   = 410;
   localparam int SETTLE  = 24;
   localparam int LIMIT   = 2000;

   class delta_tracker;
      logic signed [SAMPLE_W-1:0] history [SPAN][MAX_B];
      int unsigned band_idx;
      int unsigned frames_held;
      int unsigned ring_slot;
      logic [CSR_W-1:0] bands_reg;
      longint divisor;
      cdr_rsp_type deltas_due[$];
      int mismatches;

      function new();
         band_idx = 0;
         frames_held = 0;
         ring_slot = 0;
         bands_reg = NUM_BANDS_RESET;
         mismatches = 0;
         divisor = 0;
         for (int k = 1; k <= HW; k++) divisor += 2 * k * k;
      endfunction

      function int unsigned bands_in_use(logic [CSR_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_B) return MAX_B;
         return int'(v);
      endfunction

      function bit at_utterance_start();
         return band_idx == 0 && frames_held == 0;
      endfunction

      function logic signed [SAMPLE_W-1:0] tap(int unsigned lag, int unsigned b);
         return history[(ring_slot + SPAN - (lag % SPAN)) % SPAN][b];
      endfunction

      function logic signed [SAMPLE_W-1:0] regression_delta(int unsigned lag,
                                                            int unsigned b);
         longint acc;
         longint mag;
         longint q;
         int unsigned ahead;
         int unsigned behind;
         acc = 0;
         for (int unsigned k = 1; k <= HW; k++) begin
            ahead = (lag >= k) ? lag - k : 0;
            behind = (lag + k > frames_held) ? frames_held : lag + k;
            acc += longint'(k) * (longint'(tap(ahead, b)) - longint'(tap(behind, b)));
         end
         mag = (acc < 0) ? -acc : acc;
         q = (mag + divisor / 2) / divisor;
         if (acc < 0) return (q > NEG_LIMIT) ? Q_MIN : SAMPLE_W'(-q);
         return (q > POS_LIMIT) ? Q_MAX : SAMPLE_W'(q);
      endfunction

      function void queue_delta(int unsigned lag, int unsigned b, bit last);
         cdr_rsp_type d;
         d.delta = regression_delta(lag, b);
         d.band = BAND_OUT_W'(b);
         d.frame_lag = LAG_OUT_W'(lag);
         d.utterance_end = last;
         deltas_due.insert(deltas_due.size(), d);
      endfunction

      function void note_bands(logic [CSR_W-1:0] v);
         bands_reg = v;
      endfunction

      function void take_coefficient(cdr_req_type beat);
         int unsigned in_use;
         int unsigned b;
         int unsigned top;
         bit closes;
         in_use = bands_in_use(bands_reg);
         b = band_idx % MAX_B;
         history[ring_slot][b] = beat.coefficient;
         closes = (band_idx + 1 >= in_use);
         if (beat.final_frame) begin
            top = (frames_held < HW) ? frames_held : HW;
            for (int l = top; l >= 0; l--) queue_delta(l, b, closes && l == 0);
         end else if (frames_held >= HW) begin
            queue_delta(HW, b, 1'b0);
         end
         if (closes) begin
            band_idx = 0;
            if (beat.final_frame) begin
               frames_held = 0;
               ring_slot = 0;
            end else begin
               if (frames_held < SPAN) frames_held++;
               ring_slot = (ring_slot + 1) % SPAN;
            end
         end else begin
            band_idx++;
         end
      endfunction

      function void check_delta(cdr_rsp_type got);
         cdr_rsp_type want;
         if (deltas_due.size() == 0) begin
            $display("%0t: delta beat with none due: delta %0d band %0d lag %0d end %0b",
                     $time, got.delta, got.band, got.frame_lag, got.utterance_end);
            mismatches++;
            return;
         end
         want = deltas_due.pop_front();
         if (got.delta !== want.delta) begin
            $display("%0t: delta expected %0d, actual %0d", $time, want.delta, got.delta);
            mismatches++;
         end
         if (got.band !== want.band) begin
            $display("%0t: band expected %0d, actual %0d", $time, want.band, got.band);
            mismatches++;
         end
         if (got.frame_lag !== want.frame_lag) begin
            $display("%0t: frame_lag expected %0d, actual %0d",
                     $time, want.frame_lag, got.frame_lag);
            mismatches++;
         end
         if (got.utterance_end !== want.utterance_end) begin
            $display("%0t: utterance_end expected %0b, actual %0b",
                     $time, want.utterance_end, got.utterance_end);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   cdr_req_if req_bus ();
   cdr_rsp_if rsp_bus ();
   cdr_csr_if csr_bus ();

   delta_tracker tracker;
   int items_sent = 0;
   int idle_cycles = 0;
   bit steady_tail = 1'b0;

   cepstral_delta_regression u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) tracker.check_delta(rsp_bus.payload);
         if (req_bus.valid && req_bus.ready) tracker.take_coefficient(req_bus.payload);
         if (csr_bus.valid && csr_bus.ready) tracker.note_bands(csr_bus.data);
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, LIMIT);
            $display("end of test: mismatches");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 16)) @(posedge clock);
         if (!steady_tail && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] random_coefficient();
      case ($urandom_range(0, 7))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] random_bands();
      case ($urandom_range(0, 11))
         0: return CSR_W'(0);
         1: return CSR_W'(32);
         2: return CSR_W'(63);
         3: return CSR_W'($urandom_range(33, 62));
         4: return CSR_W'($urandom_range(7, 31));
         default: return CSR_W'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic send(input logic signed [SAMPLE_W-1:0] value, input logic fin);
      cdr_req_type beat;
      beat.coefficient = value;
      beat.final_frame = fin;
      if (!steady_tail && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= beat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_all_deltas();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.deltas_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // raising the band count mid-utterance would read unwritten history,
   // so close the utterance with a final frame first
   task automatic set_bands(input logic [CSR_W-1:0] v);
      int unsigned tail;
      wait_all_deltas();
      if (tracker.bands_in_use(v) > tracker.bands_in_use(tracker.bands_reg) &&
          !tracker.at_utterance_start()) begin
         tail = tracker.bands_in_use(tracker.bands_reg) - tracker.band_idx;
         repeat (tail) send(random_coefficient(), 1'b1);
         wait_all_deltas();
      end
      csr_bus.valid <= 1'b1;
      csr_bus.data <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned in_use;
      int unsigned span;
      logic fin;
      tracker = new();
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data <= NUM_BANDS_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // single-frame utterance at the extremes
      set_bands(CSR_W'(2));
      send(Q_MAX, 1'b1);
      send(Q_MIN, 1'b1);
      // three frames, edges clamped on both sides
      send(Q_MAX, 1'b0);
      send(Q_MIN, 1'b0);
      send('0, 1'b0);
      send('0, 1'b0);
      send(Q_MIN, 1'b1);
      send(Q_MAX, 1'b1);
      // final flag on one band only, utterance goes on
      send(random_coefficient(), 1'b0);
      send(random_coefficient(), 1'b0);
      send(random_coefficient(), 1'b1);
      send(random_coefficient(), 1'b0);
      send(random_coefficient(), 1'b1);
      send(random_coefficient(), 1'b1);
      // zero bands behaves as one
      set_bands(CSR_W'(0));
      repeat (3) send(random_coefficient(), 1'b0);
      send(random_coefficient(), 1'b1);
      // band count lowered mid-frame
      set_bands(CSR_W'(3));
      repeat (5) send(random_coefficient(), 1'b0);
      set_bands(CSR_W'(1));
      send(random_coefficient(), 1'b1);

      while (items_sent < ITEMS) begin
         if (items_sent > ITEMS - 60) steady_tail = 1'b1;
         set_bands(random_bands());
         in_use = tracker.bands_in_use(tracker.bands_reg);
         repeat ((in_use > 8) ? 1 : $urandom_range(1, 3)) begin
            span = (in_use > 8) ? $urandom_range(1, 3) : $urandom_range(1, 7);
            for (int f = 0; f < span; f++) begin
               for (int b = 0; b < in_use && items_sent < ITEMS; b++) begin
                  fin = (f == span - 1);
                  if ($urandom_range(0, 29) == 0) fin = !fin;
                  send(random_coefficient(), fin);
               end
            end
            if ($urandom_range(0, 5) == 0) wait_all_deltas();
         end
         if (items_sent < ITEMS && in_use > 1 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, in_use - 1)) send(random_coefficient(), 1'b0);
      end

      steady_tail = 1'b1;
      wait_all_deltas();
      if (tracker.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
